### design/assert_macros.svh
// Concurrent assertion helpers for the pixel writer.
// Both sample on i_clk and are held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold on every enabled clock edge.
`define ABPW_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

// Implication: when ante holds, cons holds on the same edge.
`define ABPW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define ABPW_ASSERT(lbl, prop)
`define ABPW_ASSERT_IMP(lbl, ante, cons)

`endif

`endif

### design/abpw_pkg.sv
`default_nettype none

package abpw_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int DIM_W     = 13;
    localparam int COORD_W   = 16;
    localparam int COLOR_W   = 32;
    localparam int IDX_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CH_W      = 8;
    localparam int PROD_W    = 2 * CH_W;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);
    localparam logic [CH_W-1:0]  CH_MAX    = 8'hFF;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic        [COLOR_W-1:0] fg_color;
        logic        [COLOR_W-1:0] bg_color;
    } t_req;

    typedef struct packed {
        logic               inside_res;
        logic [IDX_W-1:0]   pixel_index;
        logic [COLOR_W-1:0] out_color;
    } t_res;

    // Dimension registers clamp at MAX_DIM on write.
    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] d;
        d = v;
        if (v > MAX_DIM_V) begin
            d = MAX_DIM_V;
        end
        return d;
    endfunction

    // floor(n / 255) for n <= 255*255: (n + 1 + (n >> 8)) >> 8
    function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] n);
        logic [PROD_W:0] t;
        t = {1'b0, n} + (PROD_W+1)'(1) + (PROD_W+1)'(n >> CH_W);
        return t[CH_W +: CH_W];
    endfunction

endpackage

`default_nettype wire

### design/alpha_blend_pixel_writer_top.sv
// RGBA8888 source-over pixel writer. A request is taken on any clock where
// start is high; busy never rises, so one pixel per clock is sustained. Each
// request yields exactly one result on o_res, flagged by o_res_valid for a
// single cycle, in request order. It passes through four pipeline registers:
// bounds check, 8x8 and row-offset multiplies, channel and index sums, and the
// divide-by-255 correction with the final select. There is no backpressure:
// the consumer must take every result in the cycle it appears. Width and
// height are written through the cfg port (always ready); the user must write
// them only while no pixel is in flight, which the block itself does not
// enforce. Values above MAX_DIM are clamped.
`default_nettype none

`include "assert_macros.svh"

module alpha_blend_pixel_writer_top
    import abpw_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire t_req                 i_req,
    output logic                      o_res_valid,
    output t_res                      o_res,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIM_W-1:0]     i_cfg_data
);

    logic [DIM_W-1:0] r_width, r_height;
    logic [DIM_W-1:0] n_width, n_height;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  n_width  = sat_dim(i_cfg_data);
                REG_IMAGE_HEIGHT: n_height = sat_dim(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= '0;
            r_height <= '0;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    // ---- stage 1: register request, bounds check ----
    logic n_inside1;
    logic r_v1, r_in1;
    t_req r_req1;

    assign n_inside1 = !i_req.x_coord[COORD_W-1] && !i_req.y_coord[COORD_W-1]
        && (COORD_W'(i_req.x_coord) < COORD_W'(r_width))
        && (COORD_W'(i_req.y_coord) < COORD_W'(r_height));

    // ---- stage 2: products ----
    logic                 r_v2, r_in2;
    logic [2*DIM_W-1:0]   r_row2;
    logic [DIM_W-1:0]     r_x2;
    logic [PROD_W-1:0]    r_pf2 [3];
    logic [PROD_W-1:0]    r_pb2 [3];
    logic [COLOR_W-1:0]   r_bg2;

    // ---- stage 3: sums ----
    logic                 r_v3, r_in3;
    logic [IDX_W-1:0]     r_idx3;
    logic [PROD_W-1:0]    r_sum3 [3];
    logic [COLOR_W-1:0]   r_bg3;

    logic [CH_W-1:0]      alpha1;
    logic [PROD_W-1:0]    n_pf [3];
    logic [PROD_W-1:0]    n_pb [3];
    logic [2*DIM_W:0]     n_idx;
    t_res                 n_res;

    assign alpha1 = r_req1.fg_color[CH_W-1:0];

    always_comb begin
        // channel k: R at bits 31:24, G 23:16, B 15:8
        for (int k = 0; k < 3; k++) begin
            n_pf[k] = alpha1 * r_req1.fg_color[COLOR_W-CH_W*(k+1) +: CH_W];
            n_pb[k] = (CH_MAX - alpha1) * r_req1.bg_color[COLOR_W-CH_W*(k+1) +: CH_W];
        end
    end

    assign n_idx = (2*DIM_W+1)'(r_row2) + (2*DIM_W+1)'(r_x2);

    always_comb begin
        n_res.inside_res = r_in3;
        if (r_in3) begin
            n_res.pixel_index = r_idx3;
            n_res.out_color   = {div255(r_sum3[0]), div255(r_sum3[1]),
                                 div255(r_sum3[2]), CH_MAX};
        end else begin
            n_res.pixel_index = '0;
            n_res.out_color   = r_bg3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            o_res_valid <= 1'b0;
        end else begin
            r_v1        <= start && !busy;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            o_res_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req1 <= i_req;
        r_in1  <= n_inside1;

        r_in2  <= r_in1;
        r_bg2  <= r_req1.bg_color;
        // when inside, y < height <= MAX_DIM so the low DIM_W bits carry y
        r_row2 <= DIM_W'(r_req1.y_coord) * r_width;
        r_x2   <= DIM_W'(r_req1.x_coord);
        for (int k = 0; k < 3; k++) begin
            r_pf2[k] <= n_pf[k];
            r_pb2[k] <= n_pb[k];
        end

        r_in3  <= r_in2;
        r_bg3  <= r_bg2;
        r_idx3 <= n_idx[IDX_W-1:0];
        // a*f + (255-a)*b never exceeds 255*255
        for (int k = 0; k < 3; k++) begin
            r_sum3[k] <= PROD_W'(r_pf2[k] + r_pb2[k]);
        end

        o_res  <= n_res;
    end

    `ABPW_ASSERT(a_latency, (start && !busy) |-> ##4 o_res_valid)
    `ABPW_ASSERT_IMP(a_outside_zero_idx, o_res_valid && !o_res.inside_res,
        o_res.pixel_index == '0)
    `ABPW_ASSERT_IMP(a_inside_opaque, o_res_valid && o_res.inside_res,
        o_res.out_color[CH_W-1:0] == CH_MAX)
    `ABPW_ASSERT(a_dim_clamped, (r_width <= MAX_DIM_V) && (r_height <= MAX_DIM_V))

endmodule

`default_nettype wire

### test/tb_alpha_blend_pixel_writer_top.sv
module tb_alpha_blend_pixel_writer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import abpw_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;
    localparam int N_PHASES   = 8;
    localparam int PHASE_REQS = 125;

    class blend_scoreboard;
        int unsigned img_w;
        int unsigned img_h;
        t_res        expected_pixels[$];
        int unsigned failures;
        int unsigned checked;
        int unsigned hits;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
            int unsigned d;
            d = (data > MAX_DIM) ? MAX_DIM : data;
            case (idx)
                REG_IMAGE_WIDTH:  img_w = d;
                REG_IMAGE_HEIGHT: img_h = d;
                default: ;  // spare indexes are ignored by the block
            endcase
        endfunction

        function void note_pixel(t_req r);
            t_res        res;
            int          sx;
            int          sy;
            int unsigned a;
            int unsigned ch;
            sx = int'(r.x_coord);
            sy = int'(r.y_coord);
            res = '0;
            if (sx >= 0 && sy >= 0 && sx < int'(img_w) && sy < int'(img_h)) begin
                res.inside_res  = 1'b1;
                res.pixel_index = IDX_W'(sy * int'(img_w) + sx);
                a = r.fg_color[7:0];
                for (int k = 1; k < 4; k++) begin
                    ch = (a * r.fg_color[8*k +: 8] + (255 - a) * r.bg_color[8*k +: 8]) / 255;
                    res.out_color[8*k +: 8] = ch[7:0];
                end
                res.out_color[7:0] = 8'hFF;
            end else begin
                res.out_color = r.bg_color;
            end
            expected_pixels.push_back(res);
        endfunction

        function void check_pixel(t_res got);
            t_res exp_res;
            if (expected_pixels.size() == 0) begin
                if (failures < 10)
                    $display("ERROR: unexpected result idx=%h color=%h inside=%b",
                             got.pixel_index, got.out_color, got.inside_res);
                failures++;
                return;
            end
            exp_res = expected_pixels.pop_front();
            checked++;
            if (exp_res.inside_res)
                hits++;
            if (got.inside_res !== exp_res.inside_res ||
                got.pixel_index !== exp_res.pixel_index ||
                got.out_color !== exp_res.out_color) begin
                if (failures < 10)
                    $display("ERROR: pixel %0d exp inside=%b idx=%h color=%h, got inside=%b idx=%h color=%h",
                             checked, exp_res.inside_res, exp_res.pixel_index,
                             exp_res.out_color, got.inside_res, got.pixel_index,
                             got.out_color);
                failures++;
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_req                 i_req;
    logic                 o_res_valid;
    t_res                 o_res;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DIM_W-1:0]     i_cfg_data;

    blend_scoreboard sb = new();
    int unsigned     reg_writes;

    alpha_blend_pixel_writer_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_pixel(i_req);
            if (o_res_valid)
                sb.check_pixel(o_res);
        end
    end

    function automatic t_req mk_pixel(int x, int y, logic [31:0] fg, logic [31:0] bg);
        t_req r;
        r.x_coord  = 16'(x);
        r.y_coord  = 16'(y);
        r.fg_color = fg;
        r.bg_color = bg;
        return r;
    endfunction

    // coordinate on or just past an image border
    function automatic int near_border(int unsigned lim);
        int v;
        case ($urandom_range(0, 4))
            0: v = -1;
            1: v = 0;
            2: v = int'(lim) - 1;
            3: v = int'(lim);
            default: v = int'(lim) + 1;
        endcase
        return v;
    endfunction

    task automatic send_pixel(t_req r);
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // drop start and let the pipeline empty before touching registers
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, data);
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        #400_000;
        $display("tb_alpha_blend_pixel_writer_top NOT OK");
        $finish;
    end

    initial begin
        int unsigned w;
        int unsigned h;
        int unsigned idle_pct;
        int          x;
        int          y;
        t_req        r;

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_IMAGE_WIDTH;
        i_cfg_data  = '0;
        reg_writes  = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty image out of reset
        send_pixel(mk_pixel(0, 0, 32'hFFFFFFFF, 32'h12345678));
        send_pixel(mk_pixel(32767, -32768, 32'h00000000, 32'hFFFFFFFF));

        // oversized width clamps to the maximum
        settle();
        write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
        write_reg(REG_IMAGE_HEIGHT, 13'd4096);
        send_pixel(mk_pixel(0, 0, 32'hFFFFFFFF, 32'h00000000));
        send_pixel(mk_pixel(4095, 4095, 32'h00000000, 32'hFFFFFFFF));
        send_pixel(mk_pixel(4096, 0, 32'hFFFFFFFF, 32'hA5A5A5A5));
        send_pixel(mk_pixel(0, 4096, 32'hFFFFFFFF, 32'h5A5A5A5A));
        send_pixel(mk_pixel(-1, 0, 32'h123456FF, 32'h87654321));
        send_pixel(mk_pixel(0, -1, 32'h123456FF, 32'h87654321));
        send_pixel(mk_pixel(-32768, -32768, 32'hFFFFFF80, 32'hFFFFFFFF));
        send_pixel(mk_pixel(32767, 32767, 32'hFFFFFF80, 32'h00000000));
        send_pixel(mk_pixel(17, 3, 32'h80FF0080, 32'h00FF80FF));
        send_pixel(mk_pixel(4095, 0, 32'hAABBCC01, 32'h55667700));
        send_pixel(mk_pixel(0, 4095, 32'hAABBCCFE, 32'h55667711));

        // zero height: nothing is inside
        settle();
        write_reg(REG_IMAGE_WIDTH, 13'd1);
        write_reg(REG_IMAGE_HEIGHT, 13'd0);
        send_pixel(mk_pixel(0, 0, 32'hFFFFFFFF, 32'h00000000));

        settle();
        write_reg(REG_IMAGE_HEIGHT, 13'd1);
        send_pixel(mk_pixel(0, 0, 32'hC0FFEEFF, 32'h00000000));
        send_pixel(mk_pixel(1, 0, 32'hC0FFEEFF, 32'h11111111));
        send_pixel(mk_pixel(0, 1, 32'hC0FFEEFF, 32'h22222222));

        // spare register indexes must not disturb the dimensions
        settle();
        write_reg(REG_UNUSED_A, 13'h1FFF);
        write_reg(REG_UNUSED_B, 13'h0000);
        send_pixel(mk_pixel(0, 0, 32'h3366997F, 32'hCC996633));

        settle();
        write_reg(REG_IMAGE_WIDTH, 13'd0);
        send_pixel(mk_pixel(0, 0, 32'h3366997F, 32'hCC996633));

        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            case (p)
                0: begin w = 1;    h = 1;    end
                1: begin w = 640;  h = 480;  end
                2: begin w = 8191; h = 1;    end
                3: begin w = 4096; h = 4096; end
                4: begin w = 13;   h = 8191; end
                5: begin w = 0;    h = 100;  end
                6: begin w = $urandom_range(0, 8191); h = $urandom_range(0, 8191); end
                default: begin w = 4097; h = 37; end
            endcase
            write_reg(REG_IMAGE_WIDTH, DIM_W'(w));
            write_reg(REG_IMAGE_HEIGHT, DIM_W'(h));
            write_reg(p[0] ? REG_UNUSED_A : REG_UNUSED_B, DIM_W'($urandom));
            idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 73 : 7);

            for (int n = 0; n < PHASE_REQS; n++) begin
                while ($urandom_range(0, 99) < idle_pct) begin
                    @(negedge i_clk);
                    start <= 1'b0;
                    i_req <= mk_pixel($urandom, $urandom, $urandom, $urandom);
                end
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        if (sb.img_w > 0 && sb.img_h > 0) begin
                            x = $urandom_range(0, sb.img_w - 1);
                            y = $urandom_range(0, sb.img_h - 1);
                        end else begin
                            x = near_border(sb.img_w);
                            y = near_border(sb.img_h);
                        end
                    end
                    6, 7: begin
                        x = near_border(sb.img_w);
                        y = near_border(sb.img_h);
                    end
                    default: begin
                        x = int'($urandom);
                        y = int'($urandom);
                    end
                endcase
                r = mk_pixel(x, y, $urandom, $urandom);
                // opaque and fully transparent requests show up often
                case ($urandom_range(0, 5))
                    0: r.fg_color[7:0] = 8'h00;
                    1: r.fg_color[7:0] = 8'hFF;
                    default: ;
                endcase
                send_pixel(r);
            end
        end

        settle();
        $display("Checked %0d pixel writes (%0d inside the image) over %0d register writes,",
                 sb.checked, sb.hits, reg_writes);
        $display("covering empty, clamped and maximum image sizes with and without input gaps.");
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("tb_alpha_blend_pixel_writer_top OK");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.failures, sb.pending());
            $display("tb_alpha_blend_pixel_writer_top NOT OK");
        end
        $finish;
    end

endmodule
